// ===== hw/rtl/sia_pkg.sv =====
// Shared types and constants for the signed integer arithmetic unit.
`default_nettype none

package sia_pkg;

  localparam int FIELD_W       = 32;
  localparam int KIND_W        = 2;
  localparam int DEFAULT_WIDTH = 32;

  typedef enum logic [KIND_W-1:0] {
    K_ADD = 2'd0,
    K_SUB = 2'd1,
    K_MUL = 2'd2,
    K_DIV = 2'd3
  } kind_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic capture;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic done;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sia_ctrl.sv =====
// Controller state machine: input acceptance, iteration sequencing and output valid.
`default_nettype none

module sia_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  wire                 out_tready,
  input  sia_pkg::dp_status_t status,
  output sia_pkg::ctrl_cmd_t  cmd
);
  import sia_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd.load    = 1'b0;
    cmd.step    = 1'b0;
    cmd.capture = 1'b0;
    state_nxt   = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (!status.done) begin
          cmd.step = 1'b1;
        end else if (!out_valid_r || out_tready) begin
          // The output register is free or empties in this cycle.
          cmd.capture = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.capture) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sia_datapath.sv =====
// Datapath: operand registers, shift-add multiplier, restoring divider and result register.
`default_nettype none

module sia_datapath #(
  parameter int WIDTH = sia_pkg::DEFAULT_WIDTH
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire  [sia_pkg::KIND_W-1:0]   kind,
  input  wire  [sia_pkg::FIELD_W-1:0]  operand_a,
  input  wire  [sia_pkg::FIELD_W-1:0]  operand_b,
  input  sia_pkg::ctrl_cmd_t           cmd,
  output sia_pkg::dp_status_t          status,
  output logic [sia_pkg::FIELD_W-1:0]  result,
  output logic                         div_by_zero
);
  import sia_pkg::*;

  localparam int CW = $clog2(WIDTH + 1);

  kind_t                kind_r;
  logic                 neg_r;
  logic                 dz_r;
  logic [WIDTH-1:0]     a_r;
  logic [WIDTH-1:0]     b_r;
  logic [WIDTH-1:0]     acc_r;
  logic [WIDTH-1:0]     quo_r;
  logic [CW-1:0]        cnt_r;
  logic [FIELD_W-1:0]   res_out_r;
  logic                 dz_out_r;

  logic signed [WIDTH-1:0] a_w;
  logic signed [WIDTH-1:0] b_w;
  logic [WIDTH-1:0]        a_mag;
  logic [WIDTH-1:0]        b_mag;
  logic [WIDTH:0]          rem_sh;
  logic [WIDTH:0]          rem_diff;
  logic [WIDTH-1:0]        div_res;
  logic signed [WIDTH-1:0] final_res;

  // Operands are brought to WIDTH bits with their sign carried upward.
  assign a_w   = WIDTH'(signed'(operand_a));
  assign b_w   = WIDTH'(signed'(operand_b));
  assign a_mag = a_w[WIDTH-1] ? WIDTH'(-a_w) : a_w;
  assign b_mag = b_w[WIDTH-1] ? WIDTH'(-b_w) : b_w;

  // The remainder stays below the divisor magnitude, so one extra bit covers the shift.
  assign rem_sh   = {acc_r, a_r[WIDTH-1]};
  assign rem_diff = rem_sh - {1'b0, b_r};

  assign status.done = (cnt_r == '0);

  always_comb begin
    if (dz_r) begin
      div_res = '0;
    end else if (neg_r) begin
      div_res = WIDTH'(-quo_r);
    end else if (quo_r[WIDTH-1]) begin
      // Only the most negative value divided by minus one lands here.
      div_res = {1'b0, {(WIDTH-1){1'b1}}};
    end else begin
      div_res = quo_r;
    end
    if (kind_r == K_DIV) begin
      final_res = div_res;
    end else begin
      final_res = acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.load) begin
      if (kind_t'(kind) == K_MUL || (kind_t'(kind) == K_DIV && b_w != '0)) begin
        cnt_r <= CW'(WIDTH);
      end else begin
        cnt_r <= '0;
      end
    end else if (cmd.step) begin
      cnt_r <= cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= kind_t'(kind);
      neg_r  <= a_w[WIDTH-1] ^ b_w[WIDTH-1];
      dz_r   <= (kind_t'(kind) == K_DIV) && (b_w == '0);
      quo_r  <= '0;
      case (kind_t'(kind))
        K_ADD: begin
          acc_r <= WIDTH'(a_w + b_w);
          a_r   <= a_w;
          b_r   <= b_w;
        end
        K_SUB: begin
          acc_r <= WIDTH'(a_w - b_w);
          a_r   <= a_w;
          b_r   <= b_w;
        end
        K_MUL: begin
          acc_r <= '0;
          a_r   <= a_w;
          b_r   <= b_w;
        end
        default: begin
          acc_r <= '0;
          a_r   <= a_mag;
          b_r   <= b_mag;
        end
      endcase
    end else if (cmd.step) begin
      if (kind_r == K_MUL) begin
        // Low WIDTH bits of the product are the same for signed and unsigned operands.
        if (b_r[0]) begin
          acc_r <= acc_r + a_r;
        end
        a_r <= {a_r[WIDTH-2:0], 1'b0};
        b_r <= {1'b0, b_r[WIDTH-1:1]};
      end else begin
        a_r <= {a_r[WIDTH-2:0], 1'b0};
        if (!rem_diff[WIDTH]) begin
          acc_r <= rem_diff[WIDTH-1:0];
          quo_r <= {quo_r[WIDTH-2:0], 1'b1};
        end else begin
          acc_r <= rem_sh[WIDTH-1:0];
          quo_r <= {quo_r[WIDTH-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      res_out_r <= FIELD_W'(final_res);
      dz_out_r  <= dz_r;
    end
  end

  assign result      = res_out_r;
  assign div_by_zero = dz_out_r;

endmodule

`default_nettype wire

// ===== hw/rtl/signed_int_arith_unit_top.sv =====
// Top level of the signed integer arithmetic unit: controller and datapath.
//
//   Channel   Direction  tdata (low bit up)               tuser
//   in_       slave      operand_a[31:0], operand_b[63:32]  kind[1:0]
//   out_      master     result[31:0]                       div_by_zero[0]
//
// Add and subtract are computed when the input is loaded and go to the output register
// on the capture that follows; multiply and divide first run the one-bit-per-cycle
// shift-add or restoring shift-subtract loop in the datapath.
// A divide by zero skips the loop.
// The next input transfer is taken only once the item in progress has been captured
// into the output register and the controller is back in idle.
// The result sits in an output register, so the next item is taken while it waits.
// Reset is synchronous and active low; it clears the controller and output valid.
// A stalled output holds the finished item in the datapath until the register frees.
`default_nettype none

module signed_int_arith_unit_top #(
  parameter int WIDTH = sia_pkg::DEFAULT_WIDTH
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [63:0] in_tdata,   // operand_a [31:0], operand_b [63:32]
  input  wire  [1:0]  in_tuser,   // kind [1:0]
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [31:0] out_tdata,  // result [31:0]
  output logic        out_tuser   // div_by_zero [0]
);
  import sia_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  sia_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  sia_datapath #(
    .WIDTH (WIDTH)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .kind        (in_tuser),
    .operand_a   (in_tdata[31:0]),
    .operand_b   (in_tdata[63:32]),
    .cmd         (cmd),
    .status      (status),
    .result      (out_tdata),
    .div_by_zero (out_tuser)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/sia_checker.sv =====
// Port-level checks for the signed integer arithmetic unit, bound to the top level.
`default_nettype none

module sia_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tvalid,
  input wire        in_tready,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [31:0] out_tdata,
  input wire        out_tuser
);

  // A result that is not taken stays on offer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn before its transfer");

  // After an input transfer the unit is busy and takes no further item.
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second input taken while an item is in progress");

  // A divide by zero always reports a zero quotient.
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 32'd0)
    else $error("divide by zero with a non-zero result");

  // Reset leaves no result on offer and the input open.
  a_reset_clear: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid && in_tready)
    else $error("reset did not clear the unit");

endmodule

bind signed_int_arith_unit_top sia_checker u_sia_checker (.*);

`default_nettype wire
